>>> sv/mdlrt_pkg.sv
// Shared types, constants and saturating arithmetic for the residency tracker.
package mdlrt_pkg;

  localparam int KEY_W = 24;
  localparam int CAP_W = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int NUM_CAP = 4;
  localparam int IN_DATA_W = 32;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 240;
  localparam int OUT_USER_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_FILTER = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CAP_DEV0 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CAP_DEV1 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CAP_DEV2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CAP_DEV3 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
  } ctrl_cmd_t;

  function automatic logic [7:0] sat_inc8(input logic [7:0] a);
    return (a == 8'hFF) ? a : a + 8'd1;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] a);
    return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
  endfunction

  function automatic logic [31:0] sat_add32_8(input logic [31:0] a, input logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> sv/mdlrt_ctrl.sv
// Sequencer: capture, lookup and update steps plus the result valid flag.
module mdlrt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output mdlrt_pkg::ctrl_cmd_t  cmd
);

  mdlrt_pkg::state_t state, state_next;
  logic out_busy;

  assign out_busy = m_tvalid && !m_tready;
  assign s_tready = (state == mdlrt_pkg::ST_IDLE);
  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.lookup = (state == mdlrt_pkg::ST_LOOKUP);
  assign cmd.update = (state == mdlrt_pkg::ST_UPDATE) && !out_busy;

  always_comb begin
    state_next = state;
    case (state)
      mdlrt_pkg::ST_IDLE: begin
        if (cmd.capture) state_next = mdlrt_pkg::ST_LOOKUP;
      end
      mdlrt_pkg::ST_LOOKUP: begin
        state_next = mdlrt_pkg::ST_UPDATE;
      end
      mdlrt_pkg::ST_UPDATE: begin
        if (!out_busy) state_next = mdlrt_pkg::ST_IDLE;
      end
      default: begin
        state_next = mdlrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdlrt_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

>>> sv/mdlrt_datapath.sv
// Residency stores, LRU lookup and update, counters and result register.
module mdlrt_datapath #(
  parameter int DEVICES = 4,
  parameter int ENTRIES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mdlrt_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mdlrt_pkg::CAP_W-1:0]           cfg_data,
  input  mdlrt_pkg::ctrl_cmd_t                  cmd,
  input  logic [mdlrt_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic [mdlrt_pkg::IN_USER_W-1:0]       s_tuser,
  input  logic                                  s_tlast,
  output logic [mdlrt_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [mdlrt_pkg::OUT_USER_W-1:0]      m_tuser
);

  localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int SLOTS = DEVICES * ENTRIES;

  logic [mdlrt_pkg::KEY_W-1:0] key_st [SLOTS];
  logic                        valid_st [SLOTS];
  logic [AW-1:0]               age_st [SLOTS];
  logic [OW-1:0]               occ [DEVICES];

  logic                        phase_filter;
  logic [mdlrt_pkg::CAP_W-1:0] cap [mdlrt_pkg::NUM_CAP];

  logic [mdlrt_pkg::KEY_W-1:0] key_q;
  logic [DW-1:0]               dev_q;
  logic                        phase_q, nosel_q, last_q;

  logic          hit_q, full_q;
  logic [AW-1:0] slot_q;
  logic [AW:0]   aref_q;

  logic [7:0]  ev_sel [DEVICES];
  logic [7:0]  ev_miss [DEVICES];
  logic [31:0] dev_sel [DEVICES];
  logic [31:0] dev_miss [DEVICES];
  logic [31:0] tot_events, tot_sel, tot_miss, crit_miss, crit_comp;

  logic [1:0]  dev_mod;
  logic [SLOTS-1:0] match_all, free_all, old_all;
  logic [ENTRIES-1:0] grp_match, grp_free, grp_old;
  logic [AW-1:0] hit_idx, free_idx, old_idx, hit_age, old_age;
  logic          hit_any, full;
  logic [mdlrt_pkg::CAP_W-1:0] cap_raw;
  logic [OW-1:0] cap_eff;
  logic [AW:0]   aref_next;
  logic [AW-1:0] slot_next;

  logic        skip, sel, close;
  logic [7:0]  ev_sel_n [DEVICES];
  logic [7:0]  ev_miss_n [DEVICES];
  logic [7:0]  max_sel, max_miss;
  logic [31:0] dev_sel_n, dev_miss_n;
  logic [31:0] tot_events_n, tot_sel_n, tot_miss_n, crit_miss_n, crit_comp_n;

  always_comb begin
    dev_mod = s_tdata[25:24];
    for (int k = 0; k < 3; k++) begin
      if (dev_mod >= DEVICES) dev_mod = dev_mod - 2'(DEVICES);
    end
  end

  always_comb begin
    for (int e = 0; e < SLOTS; e++) begin
      match_all[e] = valid_st[e] && (key_st[e] == key_q);
      free_all[e] = !valid_st[e];
      old_all[e] = valid_st[e] && (age_st[e] == AW'(occ[e / ENTRIES] - OW'(1)));
    end
    grp_match = match_all[int'(dev_q) * ENTRIES +: ENTRIES];
    grp_free = free_all[int'(dev_q) * ENTRIES +: ENTRIES];
    grp_old = old_all[int'(dev_q) * ENTRIES +: ENTRIES];
    hit_any = |grp_match;
    hit_idx = '0;
    hit_age = '0;
    old_idx = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (grp_match[i]) begin
        hit_idx = hit_idx | AW'(i);
        hit_age = hit_age | age_st[int'(dev_q) * ENTRIES + i];
      end
      if (grp_old[i]) old_idx = old_idx | AW'(i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (grp_free[i]) free_idx = AW'(i);
    end
    cap_raw = cap[2'(dev_q)];
    if (cap_raw == '0) cap_eff = OW'(1);
    else if (cap_raw > ENTRIES) cap_eff = OW'(ENTRIES);
    else cap_eff = OW'(cap_raw);
    full = occ[dev_q] >= cap_eff;
    old_age = AW'(occ[dev_q] - OW'(1));
    if (hit_any) begin
      aref_next = {1'b0, hit_age};
      slot_next = hit_idx;
    end else if (full) begin
      aref_next = {1'b0, old_age};
      slot_next = old_idx;
    end else begin
      aref_next = (AW + 1)'(ENTRIES);
      slot_next = free_idx;
    end
  end

  always_comb begin
    skip = phase_filter && !phase_q;
    sel = !skip && !nosel_q;
    close = !skip && (nosel_q || last_q);
    max_sel = '0;
    max_miss = '0;
    for (int d = 0; d < DEVICES; d++) begin
      ev_sel_n[d] = ev_sel[d];
      ev_miss_n[d] = ev_miss[d];
      if (sel && (dev_q == DW'(d))) begin
        ev_sel_n[d] = mdlrt_pkg::sat_inc8(ev_sel[d]);
        if (!hit_q) ev_miss_n[d] = mdlrt_pkg::sat_inc8(ev_miss[d]);
      end
      if (ev_sel_n[d] > max_sel) max_sel = ev_sel_n[d];
      if (ev_miss_n[d] > max_miss) max_miss = ev_miss_n[d];
    end
    if (!close) begin
      max_sel = '0;
      max_miss = '0;
    end
    dev_sel_n = sel ? mdlrt_pkg::sat_inc32(dev_sel[dev_q]) : dev_sel[dev_q];
    dev_miss_n = (sel && !hit_q) ? mdlrt_pkg::sat_inc32(dev_miss[dev_q]) : dev_miss[dev_q];
    tot_sel_n = sel ? mdlrt_pkg::sat_inc32(tot_sel) : tot_sel;
    tot_miss_n = (sel && !hit_q) ? mdlrt_pkg::sat_inc32(tot_miss) : tot_miss;
    tot_events_n = close ? mdlrt_pkg::sat_inc32(tot_events) : tot_events;
    crit_miss_n = mdlrt_pkg::sat_add32_8(crit_miss, max_miss);
    crit_comp_n = mdlrt_pkg::sat_add32_8(crit_comp, max_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_filter <= 1'b1;
      for (int c = 0; c < mdlrt_pkg::NUM_CAP; c++) cap[c] <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_addr)
        mdlrt_pkg::REG_PHASE_FILTER: phase_filter <= cfg_data[0];
        mdlrt_pkg::REG_CAP_DEV0: cap[0] <= cfg_data;
        mdlrt_pkg::REG_CAP_DEV1: cap[1] <= cfg_data;
        mdlrt_pkg::REG_CAP_DEV2: cap[2] <= cfg_data;
        mdlrt_pkg::REG_CAP_DEV3: cap[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_q <= s_tdata[23:0];
      dev_q <= DW'(dev_mod);
      phase_q <= s_tuser[0];
      nosel_q <= s_tuser[1];
      last_q <= s_tlast;
    end
    if (cmd.lookup) begin
      hit_q <= hit_any;
      full_q <= full;
      slot_q <= slot_next;
      aref_q <= aref_next;
    end
    if (cmd.update) begin
      for (int e = 0; e < SLOTS; e++) begin
        if (sel && (e / ENTRIES == int'(dev_q)) && (AW'(e % ENTRIES) == slot_q)) begin
          key_st[e] <= key_q;
        end
      end
      m_tuser <= {close, skip, sel && hit_q};
      m_tdata <= {(sel ? dev_miss_n : 32'd0), (sel ? dev_sel_n : 32'd0),
                  (close ? crit_comp_n : crit_comp), (close ? crit_miss_n : crit_miss),
                  tot_miss_n, tot_sel_n, tot_events_n, max_miss, max_sel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < SLOTS; e++) begin
        valid_st[e] <= 1'b0;
        age_st[e] <= '0;
      end
      for (int d = 0; d < DEVICES; d++) begin
        occ[d] <= '0;
        ev_sel[d] <= '0;
        ev_miss[d] <= '0;
        dev_sel[d] <= '0;
        dev_miss[d] <= '0;
      end
      tot_events <= '0;
      tot_sel <= '0;
      tot_miss <= '0;
      crit_miss <= '0;
      crit_comp <= '0;
    end else if (cmd.update) begin
      for (int e = 0; e < SLOTS; e++) begin
        if (sel && (e / ENTRIES == int'(dev_q))) begin
          if (AW'(e % ENTRIES) == slot_q) begin
            valid_st[e] <= 1'b1;
            age_st[e] <= '0;
          end else if (valid_st[e] && ({1'b0, age_st[e]} < aref_q)) begin
            age_st[e] <= age_st[e] + AW'(1);
          end
        end
      end
      for (int d = 0; d < DEVICES; d++) begin
        ev_sel[d] <= close ? 8'd0 : ev_sel_n[d];
        ev_miss[d] <= close ? 8'd0 : ev_miss_n[d];
      end
      if (sel && !hit_q && !full_q) occ[dev_q] <= occ[dev_q] + OW'(1);
      dev_sel[dev_q] <= dev_sel_n;
      dev_miss[dev_q] <= dev_miss_n;
      tot_events <= tot_events_n;
      tot_sel <= tot_sel_n;
      tot_miss <= tot_miss_n;
      if (close) begin
        crit_miss <= crit_miss_n;
        crit_comp <= crit_comp_n;
      end
    end
  end

endmodule

>>> sv/multi_device_lru_residency_tracker_core.sv
// Top level of the per-device LRU residency tracker.
// Each accepted selection passes through the accept cycle, a lookup cycle with a parallel
// key compare across the selected device's store, and an update cycle that rewrites the LRU
// ages, counters and the result register; the input is ready again in the cycle after the
// update, so a new item is taken only once the last one is through, and the result valid flag
// is registered from the update. The update waits while an earlier result is still held
// on the output. Inputs: tdata = layer, expert, device; tuser = phase_decode, no_selection;
// tlast = last_of_event. Configuration: index 0 phase filter enable, 1..4 capacities.
module multi_device_lru_residency_tracker_core #(
  parameter int DEVICES = 4,
  parameter int ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mdlrt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mdlrt_pkg::CAP_W-1:0]       cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // layer[15:0], expert[23:16], device[25:24], zero fill
  input  logic [mdlrt_pkg::IN_DATA_W-1:0]   s_tdata,
  // phase_decode[0], no_selection[1]
  input  logic [mdlrt_pkg::IN_USER_W-1:0]   s_tuser,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // event_max_selections, event_max_misses, total_events, total_selections, total_misses,
  // critical_miss_total, critical_compute_total, device_selection_count, device_miss_count
  output logic [mdlrt_pkg::OUT_DATA_W-1:0]  m_tdata,
  // hit[0], skipped[1], event_done[2]
  output logic [mdlrt_pkg::OUT_USER_W-1:0]  m_tuser
);

  mdlrt_pkg::ctrl_cmd_t cmd;

  mdlrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd)
  );

  mdlrt_datapath #(.DEVICES(DEVICES), .ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .cmd(cmd), .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  a_update_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> m_tvalid) else $error("result not presented after update");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("item accepted while busy");

  a_skip_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && !m_tuser[2])
    else $error("skipped item with hit or event_done");

  a_max_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] |-> m_tdata[15:0] == 16'd0)
    else $error("event maxima without event_done");

endmodule
